>>> design/ckst_pkg.sv
package ckst_pkg;

  // Default number of table entries, one per cell.
  localparam int unsigned CAPACITY_DEF = 128;

  // Widths of the word fields.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned VALUE_W = 32;

  // Input and output word widths, padded to whole bytes.
  localparam int unsigned IN_W      = OP_W + KEY_W + VALUE_W;
  localparam int unsigned IN_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W      = 1 + VALUE_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  // Value reported on every miss and for insert and remove.
  localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // One stored entry as a cell shows it to its left neighbor.
  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // Request that travels down the chain, one cell per cycle.
  typedef struct packed {
    logic                      active;
    logic [OP_W-1:0]           op;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    logic                      found;
    logic                      placed;
    logic signed [VALUE_W-1:0] rdval;
  } pkt_t;

  // Finished result word.
  typedef struct packed {
    logic                      table_full;
    logic signed [VALUE_W-1:0] read_value;
    logic                      hit;
  } res_t;

endpackage

>>> design/ckst_cell.sv
module ckst_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ckst_pkg::pkt_t   pkt_i,
  output ckst_pkg::pkt_t   pkt_o,
  input  ckst_pkg::entry_t right_i,
  input  logic            shift_i,
  output ckst_pkg::entry_t entry_o
);
  import ckst_pkg::*;

  logic                      valid_q, valid_d;
  logic [KEY_W-1:0]          key_q, key_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  pkt_t                      pkt_q, pkt_d;
  logic                      match;

  assign match = valid_q && (key_q == pkt_i.key);

  // Update this entry from the passing request or from the right neighbor.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    pkt_d   = pkt_i;
    // A removal upstream closes the gap: take the right neighbor's entry.
    if (shift_i) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
      value_d = right_i.value;
    end
    if (pkt_i.active) begin
      case (op_e'(pkt_i.op))
        OP_INSERT: begin
          if (match) begin
            value_d     = pkt_i.value;
            pkt_d.found = 1'b1;
          end else if (!valid_q && !pkt_i.found && !pkt_i.placed) begin
            // First free cell: append the new entry here.
            valid_d      = 1'b1;
            key_d        = pkt_i.key;
            value_d      = pkt_i.value;
            pkt_d.placed = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (match) begin
            pkt_d.found = 1'b1;
            pkt_d.rdval = value_q;
          end
        end
        OP_REMOVE: begin
          if (match) begin
            pkt_d.found = 1'b1;
            valid_d     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and the passing request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pkt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pkt_q   <= pkt_d;
    end
  end

  // Stored key and value.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign pkt_o   = pkt_q;
  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

>>> design/char_key_symbol_table_core.sv
// Channel  | Direction | tdata fields, lowest bit first
// s_axis   | in        | operation[1:0], key_code[9:2], new_value[41:10]
// m_axis   | out       | hit[0], read_value[32:1], table_full[33]
//
// Each request walks the row of CAPACITY cells, one cell per cycle, and a new word
// is accepted only after the request has left the row.
// The result of a request reaches m_axis through the output register.
// Reset clears all valid bits; the table is empty at once, with no sweep.
// A finished result waits in the output register, with one hold stage behind
// it; input is stalled only while a request is in the row or the hold is full.
module char_key_symbol_table_core #(
  parameter int unsigned CAPACITY = ckst_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // operation[1:0], key_code[9:2], new_value[41:10]
  input  logic [ckst_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // hit[0], read_value[32:1], table_full[33]
  output logic [ckst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import ckst_pkg::*;

  pkt_t          chain [CAPACITY+1];
  entry_t        ent   [CAPACITY];
  logic          shift [CAPACITY];
  logic [CAPACITY:1] act;

  logic          in_fire, out_fire, exit_pkt, out_free;
  logic          busy_q, out_v_q, hold_v_q;
  logic          busy_d, out_v_d, hold_v_d;
  res_t          out_q, hold_q, exit_res;
  res_t          out_d, hold_d;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = !busy_q && !hold_v_q;

  // Request entering the first cell.
  assign chain[0] = '{
    active: in_fire,
    op:     s_axis_tdata_i[OP_W-1:0],
    key:    s_axis_tdata_i[OP_W +: KEY_W],
    value:  signed'(s_axis_tdata_i[OP_W+KEY_W +: VALUE_W]),
    found:  1'b0,
    placed: 1'b0,
    rdval:  MISS_VALUE
  };

  // Row of cells; a removal pulls each later entry one place down.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign shift[i] = chain[i+1].active && chain[i+1].found &&
                      (chain[i+1].op == OP_REMOVE);
    if (i + 1 < CAPACITY) begin : g_inner
      ckst_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .pkt_i   (chain[i]),
        .pkt_o   (chain[i+1]),
        .right_i (ent[i+1]),
        .shift_i (shift[i]),
        .entry_o (ent[i])
      );
    end else begin : g_last
      // The last cell empties itself once a removal that found its key has passed it.
      ckst_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .pkt_i   (chain[i]),
        .pkt_o   (chain[i+1]),
        .right_i ('{valid: 1'b0, key: '0, value: '0}),
        .shift_i (shift[i]),
        .entry_o (ent[i])
      );
    end
  end

  for (genvar i = 1; i <= CAPACITY; i++) begin : g_act
    assign act[i] = chain[i].active;
  end

  // Result of the request leaving the last cell.
  assign exit_pkt = chain[CAPACITY].active;
  assign exit_res = '{
    table_full: (chain[CAPACITY].op == OP_INSERT) && !chain[CAPACITY].found &&
                !chain[CAPACITY].placed,
    read_value: chain[CAPACITY].rdval,
    hit:        chain[CAPACITY].found
  };
  assign out_free = !out_v_q || m_axis_tready_i;

  // Next state of the busy flag, the output register and the hold stage.
  always_comb begin
    busy_d   = busy_q;
    out_v_d  = out_v_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    hold_d   = hold_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (exit_pkt) begin
      busy_d = 1'b0;
    end
    if (out_fire) begin
      out_v_d = 1'b0;
    end
    if (hold_v_q && out_free) begin
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
      out_d    = hold_q;
    end
    if (exit_pkt) begin
      if (out_free) begin
        out_v_d = 1'b1;
        out_d   = exit_res;
      end else begin
        hold_v_d = 1'b1;
        hold_d   = exit_res;
      end
    end
  end

  // Busy flag and output valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      out_v_q  <= out_v_d;
      hold_v_q <= hold_v_d;
    end
  end

  // Output and hold payload.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_q);

  // At most one request is in the row at any time.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(act[CAPACITY:1]) <= 1)
    else $error("more than one request in the cell row");

  // No request travels while the block is idle.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !(|act[CAPACITY:1]))
    else $error("request in the row while idle");

  // A result leaves the row only for an accepted request.
  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_pkt |-> busy_q)
    else $error("result without a request");

  // The hold stage is only used behind a full output register.
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> out_v_q)
    else $error("hold stage full with empty output register");

endmodule
